// ===== design/ces_pkg.sv =====
// package for the correspondence error statistics block
// item and result structs, constants, datapath command codes, control structs
// no dependencies
package ces_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_PAIRS = 65536;
    localparam int CNT_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int DW        = 51;   // difference vector component width
    localparam int ACC_W     = 65;   // row sum of three products
    localparam int PROD_W    = 66;   // shared multiplier product

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_CT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_AB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_CT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_AB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_CT = 3'd5;

    localparam logic [63:0] ONE_HI = 64'(1) << (32 + FRAC_BITS);
    localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic signed [31:0] src_z;
        logic signed [31:0] dst_x;
        logic signed [31:0] dst_y;
        logic signed [31:0] dst_z;
        logic               last_pair;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      pair_error;
        logic             stats_valid;
        logic [CNT_W-1:0] pair_count;
        logic [31:0]      min_error;
        logic [31:0]      max_error;
        logic [31:0]      mean_error;
        logic [31:0]      rms_error;
        logic [31:0]      std_dev;
    } t_out_item;

    // datapath operations
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LOAD       = 5'd1;
    localparam logic [4:0] OP_MUL_XF     = 5'd2;
    localparam logic [4:0] OP_ACC_XF     = 5'd3;
    localparam logic [4:0] OP_MUL_SQ     = 5'd4;
    localparam logic [4:0] OP_ACC_SQ     = 5'd5;
    localparam logic [4:0] OP_SQRT_ERR   = 5'd6;
    localparam logic [4:0] OP_ERR        = 5'd7;
    localparam logic [4:0] OP_MUL_ERR    = 5'd8;
    localparam logic [4:0] OP_UPDATE     = 5'd9;
    localparam logic [4:0] OP_EMIT_PAIR  = 5'd10;
    localparam logic [4:0] OP_DIV_MEAN   = 5'd11;
    localparam logic [4:0] OP_MEAN       = 5'd12;
    localparam logic [4:0] OP_MUL_M2     = 5'd13;
    localparam logic [4:0] OP_M2         = 5'd14;
    localparam logic [4:0] OP_MUL_NLO    = 5'd15;
    localparam logic [4:0] OP_NLO        = 5'd16;
    localparam logic [4:0] OP_MUL_NHI    = 5'd17;
    localparam logic [4:0] OP_NHI        = 5'd18;
    localparam logic [4:0] OP_DIV_RMS    = 5'd19;
    localparam logic [4:0] OP_SQRT_RMS   = 5'd20;
    localparam logic [4:0] OP_RMS        = 5'd21;
    localparam logic [4:0] OP_DIV_DEV    = 5'd22;
    localparam logic [4:0] OP_SQRT_DEV   = 5'd23;
    localparam logic [4:0] OP_DEV        = 5'd24;
    localparam logic [4:0] OP_DEV_ZERO   = 5'd25;
    localparam logic [4:0] OP_EMIT_STATS = 5'd26;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] row;
        logic [1:0] col;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic closing;
        logic dev_ok;
        logic out_free;
    } t_status;

endpackage

// ===== design/ces_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// 64-bit dividend by 17-bit divisor; uses ces_pkg
module ces_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [ces_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [63:0]               o_quotient
);

    logic                      r_busy;
    logic                      r_done;
    logic [5:0]                r_cnt;
    logic [63:0]               r_q;
    logic [ces_pkg::CNT_W-1:0] r_rem;
    logic [ces_pkg::CNT_W-1:0] r_dvs;
    logic [ces_pkg::CNT_W:0]   rem_sh;
    logic [ces_pkg::CNT_W:0]   rem_sub;
    logic                      fits;

    assign rem_sh  = {r_rem, r_q[63]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], fits};
            r_rem <= fits ? rem_sub[ces_pkg::CNT_W-1:0] : rem_sh[ces_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== design/ces_sqrt.sv =====
// iterative integer square root, one root bit per cycle
// floor(sqrt) of a 64-bit value in 32 steps; no dependencies
module ces_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_sub;
    logic        fits;

    assign rem_sh  = {r_rem, r_rad[63:62]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign fits    = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= fits ? rem_sub[33:0] : rem_sh[33:0];
            r_root <= {r_root[30:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/ces_dp.sv =====
// datapath: config registers, shared multiplier, accumulators, output register
// uses ces_pkg, ces_div and ces_sqrt
module ces_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ces_pkg::t_cmd                 i_cmd,
    output ces_pkg::t_status              o_status,
    input  ces_pkg::t_in_item             i_in,
    input  logic                          i_cfg_valid,
    input  logic [ces_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ces_pkg::t_out_item            o_out
);

    logic [63:0] r_ab0, r_ab1, r_ab2, r_ct0, r_ct1, r_ct2;

    ces_pkg::t_in_item r_item;
    logic signed [ces_pkg::PROD_W-1:0] r_prod;
    logic signed [ces_pkg::ACC_W-1:0]  r_acc;
    logic signed [ces_pkg::DW-1:0]     r_d0, r_d1, r_d2;
    logic [63:0]  r_sqacc;
    logic         r_sat;
    logic [31:0]  r_err;
    logic [47:0]  r_esum;
    logic [63:0]  r_ssum;
    logic [31:0]  r_min, r_max;
    logic [ces_pkg::CNT_W-1:0] r_cnt;
    logic [31:0]  r_mean;
    logic [63:0]  r_m2, r_nlo, r_diff;
    logic         r_dev_ok;
    logic [31:0]  r_rms, r_dev;
    ces_pkg::t_out_item r_out;
    logic         r_out_valid;

    logic [63:0]                   ab_sel, ct_sel;
    logic signed [31:0]            coef, src_sel, t_sel, dst_sel;
    logic signed [ces_pkg::DW-1:0] d_sel, d_new;
    logic [ces_pkg::DW-1:0]        d_mag;
    logic signed [32:0]            mul_a, mul_b;
    logic signed [ces_pkg::PROD_W-1:0] mul_p;
    logic signed [ces_pkg::ACC_W-1:0]  acc_sum;
    logic [64:0] sq_sum, ssum_n, nm2_tot;
    logic [48:0] esum_n, nhi;
    logic        nm2_ovf;
    logic        emit;

    logic                      div_start, div_done;
    logic [63:0]               div_dividend, div_q;
    logic [ces_pkg::CNT_W-1:0] div_divisor;
    logic                      sqrt_start, sqrt_done;
    logic [63:0]               sqrt_rad;
    logic [31:0]               sqrt_root;

    // operand selection for the transform
    always_comb begin
        case (i_cmd.row)
            2'd0:    begin ab_sel = r_ab0; ct_sel = r_ct0; dst_sel = r_item.dst_x; end
            2'd1:    begin ab_sel = r_ab1; ct_sel = r_ct1; dst_sel = r_item.dst_y; end
            default: begin ab_sel = r_ab2; ct_sel = r_ct2; dst_sel = r_item.dst_z; end
        endcase
        case (i_cmd.col)
            2'd0:    begin coef = ab_sel[63:32]; src_sel = r_item.src_x; d_sel = r_d0; end
            2'd1:    begin coef = ab_sel[31:0];  src_sel = r_item.src_y; d_sel = r_d1; end
            default: begin coef = ct_sel[63:32]; src_sel = r_item.src_z; d_sel = r_d2; end
        endcase
        t_sel = ct_sel[31:0];
    end

    assign d_mag = d_sel[ces_pkg::DW-1] ? ces_pkg::DW'(-d_sel) : ces_pkg::DW'(d_sel);

    // shared multiplier
    always_comb begin
        case (i_cmd.op)
            ces_pkg::OP_MUL_XF:  begin mul_a = 33'(coef); mul_b = 33'(src_sel); end
            ces_pkg::OP_MUL_SQ:  begin
                mul_a = {1'b0, d_mag[31:0]};
                mul_b = {1'b0, d_mag[31:0]};
            end
            ces_pkg::OP_MUL_ERR: begin mul_a = {1'b0, r_err};  mul_b = {1'b0, r_err};  end
            ces_pkg::OP_MUL_M2:  begin mul_a = {1'b0, r_mean}; mul_b = {1'b0, r_mean}; end
            ces_pkg::OP_MUL_NLO: begin mul_a = {1'b0, r_m2[31:0]};  mul_b = 33'(r_cnt); end
            ces_pkg::OP_MUL_NHI: begin mul_a = {1'b0, r_m2[63:32]}; mul_b = 33'(r_cnt); end
            default:             begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // row sum, floored to integer part, plus translation, minus target
    assign acc_sum = r_acc + r_prod[ces_pkg::ACC_W-1:0];
    assign d_new   = ces_pkg::DW'(acc_sum >>> ces_pkg::FRAC_BITS) + ces_pkg::DW'(t_sel)
                   - ces_pkg::DW'(dst_sel);

    assign sq_sum  = {1'b0, r_sqacc} + {1'b0, r_prod[63:0]};
    assign esum_n  = {1'b0, r_esum} + 49'(r_err);
    assign ssum_n  = {1'b0, r_ssum} + {1'b0, r_prod[63:0]};
    assign nhi     = r_prod[48:0];
    assign nm2_tot = {1'b0, nhi[31:0], 32'd0} + {1'b0, r_nlo};
    assign nm2_ovf = (|nhi[48:32]) | nm2_tot[64];

    // iterative units
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_ssum;
        div_divisor  = r_cnt;
        case (i_cmd.op)
            ces_pkg::OP_DIV_MEAN: begin div_start = 1'b1; div_dividend = {16'd0, r_esum}; end
            ces_pkg::OP_DIV_RMS:  div_start = 1'b1;
            ces_pkg::OP_DIV_DEV:  begin
                div_start    = 1'b1;
                div_dividend = r_diff;
                div_divisor  = r_cnt - ces_pkg::CNT_W'(1);
            end
            default: ;
        endcase
        sqrt_start = (i_cmd.op == ces_pkg::OP_SQRT_ERR) || (i_cmd.op == ces_pkg::OP_SQRT_RMS)
                  || (i_cmd.op == ces_pkg::OP_SQRT_DEV);
        sqrt_rad   = (i_cmd.op == ces_pkg::OP_SQRT_ERR) ? r_sqacc : div_q;
    end

    ces_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    ces_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_rad),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign emit = (i_cmd.op == ces_pkg::OP_EMIT_PAIR) || (i_cmd.op == ces_pkg::OP_EMIT_STATS);

    // control state: config, statistics, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab0       <= ces_pkg::ONE_HI;
            r_ct0       <= '0;
            r_ab1       <= ces_pkg::ONE_LO;
            r_ct1       <= '0;
            r_ab2       <= '0;
            r_ct2       <= ces_pkg::ONE_HI;
            r_esum      <= '0;
            r_ssum      <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ces_pkg::REG_ROW0_AB: r_ab0 <= i_cfg_data;
                    ces_pkg::REG_ROW0_CT: r_ct0 <= i_cfg_data;
                    ces_pkg::REG_ROW1_AB: r_ab1 <= i_cfg_data;
                    ces_pkg::REG_ROW1_CT: r_ct1 <= i_cfg_data;
                    ces_pkg::REG_ROW2_AB: r_ab2 <= i_cfg_data;
                    ces_pkg::REG_ROW2_CT: r_ct2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == ces_pkg::OP_UPDATE) begin
                r_esum <= esum_n[48] ? '1 : esum_n[47:0];
                r_ssum <= ssum_n[64] ? '1 : ssum_n[63:0];
                if (r_err < r_min) r_min <= r_err;
                if (r_err > r_max) r_max <= r_err;
                r_cnt  <= r_cnt + ces_pkg::CNT_W'(1);
            end else if (i_cmd.op == ces_pkg::OP_EMIT_STATS) begin
                r_esum <= '0;
                r_ssum <= '0;
                r_min  <= '1;
                r_max  <= '0;
                r_cnt  <= '0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ces_pkg::OP_LOAD: begin
                r_item  <= i_in;
                r_acc   <= '0;
                r_sqacc <= '0;
                r_sat   <= 1'b0;
            end
            ces_pkg::OP_MUL_XF, ces_pkg::OP_MUL_ERR, ces_pkg::OP_MUL_M2,
            ces_pkg::OP_MUL_NLO, ces_pkg::OP_MUL_NHI: r_prod <= mul_p;
            ces_pkg::OP_MUL_SQ: begin
                r_prod <= mul_p;
                if (|d_mag[ces_pkg::DW-1:32]) r_sat <= 1'b1;
            end
            ces_pkg::OP_ACC_XF: begin
                if (i_cmd.col == 2'd2) begin
                    r_acc <= '0;
                    case (i_cmd.row)
                        2'd0:    r_d0 <= d_new;
                        2'd1:    r_d1 <= d_new;
                        default: r_d2 <= d_new;
                    endcase
                end else begin
                    r_acc <= acc_sum;
                end
            end
            ces_pkg::OP_ACC_SQ: begin
                r_sqacc <= sq_sum[63:0];
                if (sq_sum[64]) r_sat <= 1'b1;
            end
            ces_pkg::OP_ERR:  r_err  <= r_sat ? '1 : sqrt_root;
            ces_pkg::OP_MEAN: r_mean <= div_q[31:0];
            ces_pkg::OP_M2:   r_m2   <= r_prod[63:0];
            ces_pkg::OP_NLO:  r_nlo  <= r_prod[63:0];
            ces_pkg::OP_NHI: begin
                r_dev_ok <= !nm2_ovf && (r_cnt > ces_pkg::CNT_W'(1))
                            && (nm2_tot[63:0] <= r_ssum);
                r_diff   <= r_ssum - nm2_tot[63:0];
            end
            ces_pkg::OP_RMS:      r_rms <= sqrt_root;
            ces_pkg::OP_DEV:      r_dev <= sqrt_root;
            ces_pkg::OP_DEV_ZERO: r_dev <= '0;
            ces_pkg::OP_EMIT_PAIR: begin
                // statistics fields read zero on an ordinary pair
                r_out <= '{pair_error: r_err, default: '0};
            end
            ces_pkg::OP_EMIT_STATS: begin
                r_out.pair_error  <= r_err;
                r_out.stats_valid <= 1'b1;
                r_out.pair_count  <= r_cnt;
                r_out.min_error   <= r_min;
                r_out.max_error   <= r_max;
                r_out.mean_error  <= r_mean;
                r_out.rms_error   <= r_rms;
                r_out.std_dev     <= r_dev;
            end
            default: ;
        endcase
    end

    assign o_status.sqrt_done = sqrt_done;
    assign o_status.div_done  = div_done;
    assign o_status.closing   = r_item.last_pair
                             || (r_cnt == ces_pkg::CNT_W'(ces_pkg::MAX_PAIRS - 1));
    assign o_status.dev_ok    = r_dev_ok;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/ces_ctrl.sv =====
// controller state machine sequencing the datapath one item at a time
// uses ces_pkg command and status structs
module ces_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ces_pkg::t_status i_status,
    output ces_pkg::t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_XMUL   = 5'd1;
    localparam logic [4:0] S_XACC   = 5'd2;
    localparam logic [4:0] S_SMUL   = 5'd3;
    localparam logic [4:0] S_SACC   = 5'd4;
    localparam logic [4:0] S_ROOT   = 5'd5;
    localparam logic [4:0] S_RWAIT  = 5'd6;
    localparam logic [4:0] S_EMUL   = 5'd7;
    localparam logic [4:0] S_UPD    = 5'd8;
    localparam logic [4:0] S_EMITP  = 5'd9;
    localparam logic [4:0] S_DMEAN  = 5'd10;
    localparam logic [4:0] S_DMWAIT = 5'd11;
    localparam logic [4:0] S_M2MUL  = 5'd12;
    localparam logic [4:0] S_M2     = 5'd13;
    localparam logic [4:0] S_NLMUL  = 5'd14;
    localparam logic [4:0] S_NL     = 5'd15;
    localparam logic [4:0] S_NHMUL  = 5'd16;
    localparam logic [4:0] S_NH     = 5'd17;
    localparam logic [4:0] S_DRMS   = 5'd18;
    localparam logic [4:0] S_DRWAIT = 5'd19;
    localparam logic [4:0] S_SRWAIT = 5'd20;
    localparam logic [4:0] S_DDEV   = 5'd21;
    localparam logic [4:0] S_DDWAIT = 5'd22;
    localparam logic [4:0] S_SDWAIT = 5'd23;
    localparam logic [4:0] S_EMITS  = 5'd24;

    logic [4:0] r_state, n_state;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        o_cmd.op   = ces_pkg::OP_NONE;
        o_cmd.row  = r_row;
        o_cmd.col  = r_col;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ces_pkg::OP_LOAD;
                    n_row    = 2'd0;
                    n_col    = 2'd0;
                    n_state  = S_XMUL;
                end
            end
            S_XMUL: begin
                o_cmd.op = ces_pkg::OP_MUL_XF;
                n_state  = S_XACC;
            end
            S_XACC: begin
                o_cmd.op = ces_pkg::OP_ACC_XF;
                n_state  = S_XMUL;
                if (r_col == 2'd2) begin
                    n_col = 2'd0;
                    if (r_row == 2'd2) begin
                        n_state = S_SMUL;
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end else begin
                    n_col = r_col + 2'd1;
                end
            end
            S_SMUL: begin
                o_cmd.op = ces_pkg::OP_MUL_SQ;
                n_state  = S_SACC;
            end
            S_SACC: begin
                o_cmd.op = ces_pkg::OP_ACC_SQ;
                if (r_col == 2'd2) begin
                    n_state = S_ROOT;
                end else begin
                    n_col   = r_col + 2'd1;
                    n_state = S_SMUL;
                end
            end
            S_ROOT: begin
                o_cmd.op = ces_pkg::OP_SQRT_ERR;
                n_state  = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = ces_pkg::OP_ERR;
                    n_state  = S_EMUL;
                end
            end
            S_EMUL: begin
                o_cmd.op = ces_pkg::OP_MUL_ERR;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = ces_pkg::OP_UPDATE;
                n_state  = i_status.closing ? S_DMEAN : S_EMITP;
            end
            S_EMITP: begin
                if (i_status.out_free) begin
                    o_cmd.op = ces_pkg::OP_EMIT_PAIR;
                    n_state  = S_IDLE;
                end
            end
            S_DMEAN: begin
                o_cmd.op = ces_pkg::OP_DIV_MEAN;
                n_state  = S_DMWAIT;
            end
            S_DMWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ces_pkg::OP_MEAN;
                    n_state  = S_M2MUL;
                end
            end
            S_M2MUL: begin
                o_cmd.op = ces_pkg::OP_MUL_M2;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = ces_pkg::OP_M2;
                n_state  = S_NLMUL;
            end
            S_NLMUL: begin
                o_cmd.op = ces_pkg::OP_MUL_NLO;
                n_state  = S_NL;
            end
            S_NL: begin
                o_cmd.op = ces_pkg::OP_NLO;
                n_state  = S_NHMUL;
            end
            S_NHMUL: begin
                o_cmd.op = ces_pkg::OP_MUL_NHI;
                n_state  = S_NH;
            end
            S_NH: begin
                o_cmd.op = ces_pkg::OP_NHI;
                n_state  = S_DRMS;
            end
            S_DRMS: begin
                o_cmd.op = ces_pkg::OP_DIV_RMS;
                n_state  = S_DRWAIT;
            end
            S_DRWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ces_pkg::OP_SQRT_RMS;
                    n_state  = S_SRWAIT;
                end
            end
            S_SRWAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = ces_pkg::OP_RMS;
                    n_state  = S_DDEV;
                end
            end
            S_DDEV: begin
                if (i_status.dev_ok) begin
                    o_cmd.op = ces_pkg::OP_DIV_DEV;
                    n_state  = S_DDWAIT;
                end else begin
                    o_cmd.op = ces_pkg::OP_DEV_ZERO;
                    n_state  = S_EMITS;
                end
            end
            S_DDWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = ces_pkg::OP_SQRT_DEV;
                    n_state  = S_SDWAIT;
                end
            end
            S_SDWAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = ces_pkg::OP_DEV;
                    n_state  = S_EMITS;
                end
            end
            S_EMITS: begin
                if (i_status.out_free) begin
                    o_cmd.op = ces_pkg::OP_EMIT_STATS;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule

// ===== design/correspondence_error_statistics.sv =====
// top level of the correspondence error statistics block
// depends on ces_pkg, ces_ctrl and ces_dp (which holds ces_div and ces_sqrt)
//
// one source/target point pair per item, coordinates signed q16.16. the source
// point goes through the configured 3x4 affine transform and the euclidean
// distance to the target comes back as pair_error for every item. count, sum,
// sum of squares, min and max are kept across a set; the item marked last_pair
// (or the one that brings the count to MAX_PAIRS) also returns count, min, max,
// mean, rms and sample standard deviation, and then the set state clears.
// one item is worked at a time: an ordinary pair runs the nine transform and
// three square products through the single shared multiplier, then the 32-step
// square root. a closing pair adds three 64-step divisions and two more 32-step
// square roots (one division and one root fewer when the deviation is forced
// to zero). a waiting result sits in the output register while the next item
// is accepted. configuration writes are always taken; write only while no item
// is in work. indexes 6 and 7 are ignored.
module correspondence_error_statistics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ces_pkg::t_in_item             i_in,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ces_pkg::t_out_item            o_out,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ces_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    ces_pkg::t_cmd    cmd;
    ces_pkg::t_status status;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // sequencer
    ces_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic, statistics and result register
    ces_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== test/correspondence_error_statistics_tb.sv =====
// testbench for the correspondence error statistics block
// holds a scoreboard class that predicts each result, and tasks that drive the block
// depends on ces_pkg and correspondence_error_statistics
module correspondence_error_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ces_pkg::*;

    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam int     DRAIN_WAIT  = 400;   // longer than a closing pair's work
    localparam int     NUM_CFG     = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // predicts pair errors and set statistics, and checks results in order
    class error_stats_board;
        logic [63:0] xform [NUM_CFG];
        logic [47:0] err_total;
        logic [63:0] sq_total;
        logic [31:0] err_min;
        logic [31:0] err_max;
        logic [16:0] pairs_seen;
        t_out_item   expected_q [$];
        int          mismatches;

        function new();
            xform[REG_ROW0_AB] = ONE_HI;
            xform[REG_ROW0_CT] = '0;
            xform[REG_ROW1_AB] = ONE_LO;
            xform[REG_ROW1_CT] = '0;
            xform[REG_ROW2_AB] = '0;
            xform[REG_ROW2_CT] = ONE_HI;
            mismatches = 0;
            clear_set();
        endfunction

        function void clear_set();
            err_total  = '0;
            sq_total   = '0;
            err_min    = '1;
            err_max    = '0;
            pairs_seen = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx < NUM_CFG) xform[idx] = data;
        endfunction

        // integer square root, one result bit per step from the top
        function logic [31:0] root_of(logic [63:0] v);
            logic [31:0] r;
            logic [31:0] trial;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (32'd1 << b);
                if (64'(trial) * 64'(trial) <= v) r = trial;
            end
            return r;
        endfunction

        // one row of the affine map, floor of the scaled dot product plus offset
        function logic signed [65:0] map_coord(logic [63:0] ab, logic [63:0] ct,
                                               logic signed [65:0] x,
                                               logic signed [65:0] y,
                                               logic signed [65:0] z);
            logic signed [65:0] c0, c1, c2, off, dot;
            c0  = $signed(ab[63:32]);
            c1  = $signed(ab[31:0]);
            c2  = $signed(ct[63:32]);
            off = $signed(ct[31:0]);
            dot = c0 * x + c1 * y + c2 * z;
            return (dot >>> FRAC_BITS) + off;
        endfunction

        function logic [31:0] pair_distance(t_in_item it);
            logic signed [65:0] sx, sy, sz, d;
            logic [65:0]        mag;
            logic [65:0]        acc;
            sx  = it.src_x;
            sy  = it.src_y;
            sz  = it.src_z;
            acc = '0;
            for (int row = 0; row < 3; row++) begin
                d = map_coord(xform[2*row], xform[2*row+1], sx, sy, sz);
                case (row)
                    0: d = d - 66'(it.dst_x);
                    1: d = d - 66'(it.dst_y);
                    default: d = d - 66'(it.dst_z);
                endcase
                mag = d[65] ? 66'(-d) : 66'(d);
                if (mag > 66'h0_FFFF_FFFF) return '1;
                acc = acc + mag * mag;
                if (acc > 66'h0_FFFF_FFFF_FFFF_FFFF) return '1;
            end
            return root_of(acc[63:0]);
        endfunction

        function void note_pair(t_in_item it);
            t_out_item   res;
            logic [31:0] err;
            logic [48:0] esum;
            logic [64:0] ssum;
            logic [47:0] avg;
            logic [127:0] n_avg2;
            logic [63:0] spread;
            err  = pair_distance(it);
            esum = err_total + err;
            err_total = esum[48] ? '1 : esum[47:0];
            ssum = sq_total + 64'(err) * 64'(err);
            sq_total = ssum[64] ? '1 : ssum[63:0];
            if (err < err_min) err_min = err;
            if (err > err_max) err_max = err;
            pairs_seen++;

            res = '0;
            res.pair_error = err;
            if (it.last_pair || pairs_seen >= MAX_PAIRS) begin
                avg    = err_total / pairs_seen;
                n_avg2 = 128'(avg) * 128'(avg) * 128'(pairs_seen);
                spread = '0;
                // sample deviation needs two pairs; negative numerator reads as zero
                if (pairs_seen > 1 && n_avg2 <= 128'(sq_total))
                    spread = (sq_total - n_avg2[63:0]) / (pairs_seen - 1);
                res.stats_valid = 1'b1;
                res.pair_count  = pairs_seen;
                res.min_error   = err_min;
                res.max_error   = err_max;
                res.mean_error  = avg[31:0];
                res.rms_error   = root_of(sq_total / pairs_seen);
                res.std_dev     = (pairs_seen > 1) ? root_of(spread) : '0;
                clear_set();
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.pair_error  !== want.pair_error  || got.stats_valid !== want.stats_valid ||
                got.pair_count  !== want.pair_count  || got.min_error   !== want.min_error   ||
                got.max_error   !== want.max_error   || got.mean_error  !== want.mean_error  ||
                got.rms_error   !== want.rms_error   || got.std_dev     !== want.std_dev) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    error_stats_board stats_board = new();

    int     send_idle_pct = 6;
    int     recv_idle_pct = 66;
    int     recv_hold     = 0;   // cycles left in a forced receiver stall
    longint cycle_count   = 0;

    correspondence_error_statistics dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // all handshakes are observed at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) stats_board.note_pair(i_in);
            if (o_out_valid && i_out_ready) stats_board.check_result(o_out);
            if (i_cfg_valid && o_cfg_ready) stats_board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver ready, random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready = 1'b0;
        end else if (recv_hold > 0) begin
            i_out_ready = 1'b0;
            recv_hold--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high so back-to-back items need no second assignment
    task automatic send_pair(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_in_valid = 1'b0;
        while (stats_board.pending() != 0) @(negedge i_clk);
    endtask

    // register writes happen only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wait_all_results();
        repeat (20) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_xform(input logic [63:0] ab0, ct0, ab1, ct1, ab2, ct2);
        write_reg(REG_ROW0_AB, ab0);
        write_reg(REG_ROW0_CT, ct0);
        write_reg(REG_ROW1_AB, ab1);
        write_reg(REG_ROW1_CT, ct1);
        write_reg(REG_ROW2_AB, ab2);
        write_reg(REG_ROW2_CT, ct2);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'h0001_0000;
            2:       return 32'hFFFF_0000;
            3:       return $urandom_range(32'h0002_0000);
            4:       return -$urandom_range(32'h0002_0000);
            5:       return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_reg();
        return {pick_coef(), pick_coef()};
    endfunction

    function automatic logic signed [31:0] pick_coord(input int spread);
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    function automatic t_in_item pick_pair(input bit closes);
        t_in_item it;
        int       spread;
        spread = ($urandom_range(3) == 0) ? 32'h4000_0000 : 32'h0040_0000;
        it.src_x = pick_coord(spread);
        it.src_y = pick_coord(spread);
        it.src_z = pick_coord(spread);
        // mostly targets close to the source so distances stay meaningful
        if ($urandom_range(2) != 0) begin
            it.dst_x = it.src_x + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            it.dst_y = it.src_y + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            it.dst_z = it.src_z + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        end else begin
            it.dst_x = pick_coord(spread);
            it.dst_y = pick_coord(spread);
            it.dst_z = pick_coord(spread);
        end
        it.last_pair = closes;
        return it;
    endfunction

    function automatic t_in_item make_pair(input logic signed [31:0] sx, sy, sz,
                                           dx, dy, dz, input bit closes);
        t_in_item it;
        it.src_x = sx; it.src_y = sy; it.src_z = sz;
        it.dst_x = dx; it.dst_y = dy; it.dst_z = dz;
        it.last_pair = closes;
        return it;
    endfunction

    // sets of random length; one in eight sets has random last flags instead
    task automatic random_sets(input int count);
        int  sent;
        int  len;
        bit  ragged;
        sent = 0;
        while (sent < count) begin
            if (sent % 150 < 20 && sent > 0)
                load_xform(pick_reg(), pick_reg(), pick_reg(),
                           pick_reg(), pick_reg(), pick_reg());
            len    = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(1, 12);
            ragged = ($urandom_range(7) == 0);
            for (int k = 0; k < len; k++) begin
                send_pair(pick_pair(ragged ? $urandom_range(3) == 0 : k == len - 1));
                sent++;
            end
            if ($urandom_range(4) == 0) wait_all_results();
        end
        // close any open set so the next phase starts clean
        send_pair(pick_pair(1'b1));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity transform from reset
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b1));                  // single pair
        send_pair(make_pair(32'sh0001_0000, 0, 0, 0, 0, 0, 1'b0));
        send_pair(make_pair(0, 32'sh0003_0000, 0, 0, 0, 0, 1'b1));
        send_pair(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
        send_pair(make_pair(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 1'b0));
        send_pair(make_pair(-1, -1, -1, 1, 1, 1, 1'b1));
        // spare indexes must not disturb the transform
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        send_pair(make_pair(32'sh0002_0000, 0, 0, 0, 0, 0, 1'b1));
        // extreme coefficients and offsets
        load_xform('1, '1, '1, '1, '1, '1);
        send_pair(make_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 5, 0, 0, 0, 1'b0));
        send_pair(make_pair(1, 1, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1'b1));
        load_xform({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                   {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}});
        send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b1));
        load_xform({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                   {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
        send_pair(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 1'b1));
        load_xform('0, '0, '0, '0, '0, '0);
        send_pair(make_pair(3, 4, 5, 32'sh0003_0000, 32'sh0004_0000, 0, 1'b1));

        // pressure: receiver holds off while items keep coming
        load_xform(ONE_HI, '0, ONE_LO, '0, '0, ONE_HI);
        recv_hold = 800;
        for (int k = 0; k < 8; k++) send_pair(pick_pair(k == 7));
        wait_all_results();

        send_idle_pct = 6;
        recv_idle_pct = 66;
        random_sets(430);
        send_idle_pct = 66;
        recv_idle_pct = 6;
        random_sets(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_sets(430);

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (stats_board.mismatches == 0 && stats_board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
